// ===== hdl/mseu_pkg.sv =====
// Shared types, opcodes and sizes of the MIPS subset execute unit.
`default_nettype none
package mseu_pkg;

	localparam int unsigned DATA_WORDS_DEF = 1024;
	localparam int unsigned FRONT_DEPTH    = 2;
	localparam int unsigned OUT_DEPTH      = 4;
	localparam int unsigned OCW            = $clog2(OUT_DEPTH + 1);

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_BEQ  = 4'd3;
	localparam logic [3:0] OP_BNE  = 4'd4;
	localparam logic [3:0] OP_SLT  = 4'd5;
	localparam logic [3:0] OP_J    = 4'd6;
	localparam logic [3:0] OP_LW   = 4'd7;
	localparam logic [3:0] OP_SW   = 4'd8;
	localparam logic [3:0] OP_ADDI = 4'd9;

	typedef enum logic [1:0] {
		CFG_TIMING = 2'd0,
		CFG_ROW    = 2'd1,
		CFG_COL    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [3:0]         cmd;
		logic [4:0]         field_a;
		logic [4:0]         field_b;
		logic [4:0]         field_c;
		logic signed [31:0] imm;
		logic [19:0]        cur_index;
	} instr_t;

	typedef struct packed {
		logic [19:0]        next_index;
		logic               reg_we;
		logic [4:0]         reg_index;
		logic signed [31:0] reg_value;
		logic [11:0]        cycles_charged;
		logic [31:0]        cycle_total;
		logic               halted;
		logic               addr_error;
	} result_t;

	// Instruction with its class flags, as it waits between front and back.
	typedef struct packed {
		instr_t item;
		logic   is_mem;
		logic   is_halt;
	} dec_t;

	typedef struct packed {
		logic valid;
		dec_t d;
	} head_t;

endpackage
`default_nettype wire

// ===== hdl/mseu_front.sv =====
// Front end: accepts instructions, classifies them and queues them for execution.
`default_nettype none
module mseu_front import mseu_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	output logic        full,
	input  wire instr_t instr,
	input  wire logic   take,
	output head_t       head
);

	localparam int unsigned PW = $clog2(FRONT_DEPTH);
	localparam int unsigned CW = $clog2(FRONT_DEPTH + 1);

	dec_t          q_mem [FRONT_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          wr, rd;
	dec_t          dec;

	always_comb begin
		dec.item    = instr;
		dec.is_mem  = (instr.cmd == OP_LW) || (instr.cmd == OP_SW);
		dec.is_halt = instr.cmd > OP_ADDI;
	end

	assign full       = cnt_q == CW'(FRONT_DEPTH);
	assign wr         = push && !full;
	assign rd         = take && (cnt_q != '0);
	assign head.valid = cnt_q != '0;
	assign head.d     = q_mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			q_mem[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= (wp_q == PW'(FRONT_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == PW'(FRONT_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mseu_back.sv =====
// Back end: register file, data memory and the three-stage execute pipeline.
`default_nettype none
module mseu_back import mseu_pkg::*; #(
	parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [9:0]     cfg_data,
	input  wire head_t          head,
	output logic                take,
	input  wire logic [OCW-1:0] out_count,
	output logic                res_push,
	output result_t             res_item
);

	localparam int unsigned AW = $clog2(DATA_WORDS);

	// Configuration.
	logic       timing_q;
	logic [9:0] row_q, col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q <= 1'b0;
			row_q    <= 10'd10;
			col_q    <= 10'd2;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TIMING: timing_q <= cfg_data[0];
				CFG_ROW:    row_q    <= cfg_data;
				CFG_COL:    col_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clearing pass of the data memory after reset.
	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(DATA_WORDS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Pipeline state.
	logic        vld_s2, vld_s3;
	dec_t        dec_s2;
	logic [31:0] rda_s2, rdb_s2, rdc_s2;
	logic        rva_s2, rvb_s2, rvc_s2;
	logic        we_s3, lw_s3, halt_s3, aerr_s3;
	logic [4:0]  idx_s3;
	logic [31:0] alu_s3, tot_s3, dmem_rd_s3;
	logic [19:0] next_s3;
	logic [11:0] cyc_s3;
	logic        wb_w_q;
	logic [4:0]  wb_i_q;
	logic [31:0] wb_d_q;
	logic        seen_q;
	logic [31:0] cnt_q;
	logic [31:0] rf_vld_q;

	logic [OCW+1:0] pending;
	assign pending = (OCW + 2)'(out_count) + (OCW + 2)'(vld_s2) + (OCW + 2)'(vld_s3);
	assign take    = head.valid && !clr_q && (pending < (OCW + 2)'(OUT_DEPTH));

	// Register file: three copies, one read port each, written together.
	logic [31:0] rf_a [32];
	logic [31:0] rf_b [32];
	logic [31:0] rf_c [32];
	logic [31:0] s3_val;
	logic        rf_wr;

	assign s3_val = lw_s3 ? dmem_rd_s3 : alu_s3;
	assign rf_wr  = vld_s3 && we_s3;

	always_ff @(posedge clk) begin
		if (rf_wr) begin
			rf_a[idx_s3] <= s3_val;
			rf_b[idx_s3] <= s3_val;
			rf_c[idx_s3] <= s3_val;
		end
		rda_s2 <= rf_a[head.d.item.field_a];
		rdb_s2 <= rf_b[head.d.item.field_b];
		rdc_s2 <= rf_c[head.d.item.field_c];
		dec_s2 <= head.d;
	end

	function automatic logic [31:0] fwd(
		input logic [4:0]  r,
		input logic [31:0] d,
		input logic        dv,
		input logic        s3w,
		input logic [4:0]  s3i,
		input logic [31:0] s3d,
		input logic        wbw,
		input logic [4:0]  wbi,
		input logic [31:0] wbd
	);
		logic [31:0] v;
		if (r == 5'd0) begin
			v = '0;
		end else if (s3w && s3i == r) begin
			v = s3d;
		end else if (wbw && wbi == r) begin
			v = wbd;
		end else begin
			v = dv ? d : '0;
		end
		return v;
	endfunction

	// Execute stage.
	logic [31:0] va, vb, vc, imm_u, addr, wval;
	logic [19:0] nxt;
	logic [11:0] cyc;
	logic        we, halt, aerr, sw_wr, in_rng;
	logic [63:0] prod;

	always_comb begin
		va    = fwd(dec_s2.item.field_a, rda_s2, rva_s2, rf_wr, idx_s3, s3_val,
			wb_w_q, wb_i_q, wb_d_q);
		vb    = fwd(dec_s2.item.field_b, rdb_s2, rvb_s2, rf_wr, idx_s3, s3_val,
			wb_w_q, wb_i_q, wb_d_q);
		vc    = fwd(dec_s2.item.field_c, rdc_s2, rvc_s2, rf_wr, idx_s3, s3_val,
			wb_w_q, wb_i_q, wb_d_q);
		imm_u  = dec_s2.item.imm;
		addr   = vb + imm_u;
		in_rng = addr < 32'(DATA_WORDS);
		prod   = 64'(vb) * 64'(vc);
		nxt    = dec_s2.item.cur_index + 20'd4;
		we     = 1'b0;
		wval   = '0;
		halt   = dec_s2.is_halt;
		aerr   = 1'b0;
		sw_wr  = 1'b0;
		cyc    = halt ? 12'd0 : 12'd1;
		if (dec_s2.is_mem && timing_q) begin
			cyc = 12'd1 + 12'(col_q) + 12'(row_q) + (seen_q ? 12'(row_q) : 12'd0);
		end
		case (dec_s2.item.cmd)
			OP_ADD:  begin we = 1'b1; wval = vb + vc; end
			OP_SUB:  begin we = 1'b1; wval = vb - vc; end
			OP_MUL:  begin we = 1'b1; wval = prod[31:0]; end
			OP_BEQ:  if (va == vb) nxt = imm_u[19:0];
			OP_BNE:  if (va != vb) nxt = imm_u[19:0];
			OP_SLT:  begin we = 1'b1; wval = {31'd0, $signed(vb) < $signed(vc)}; end
			OP_J:    nxt = imm_u[19:0];
			OP_LW:   begin we = in_rng; aerr = !in_rng; end
			OP_SW:   begin sw_wr = in_rng; aerr = !in_rng; end
			OP_ADDI: begin we = 1'b1; wval = vb + imm_u; end
			default: nxt = dec_s2.item.cur_index;
		endcase
		if (dec_s2.item.field_a == 5'd0) begin
			we = 1'b0;
		end
	end

	// Data memory.
	logic [31:0] dmem [DATA_WORDS];
	logic          dm_we;
	logic [AW-1:0] dm_wa;
	logic [31:0]   dm_wd;

	assign dm_we = clr_q || (vld_s2 && sw_wr);
	assign dm_wa = clr_q ? clr_addr_q : addr[AW-1:0];
	assign dm_wd = clr_q ? '1 : va;

	always_ff @(posedge clk) begin
		if (dm_we) begin
			dmem[dm_wa] <= dm_wd;
		end
		dmem_rd_s3 <= dmem[addr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		we_s3   <= we;
		lw_s3   <= dec_s2.item.cmd == OP_LW;
		idx_s3  <= dec_s2.item.field_a;
		alu_s3  <= wval;
		next_s3 <= nxt;
		cyc_s3  <= cyc;
		tot_s3  <= cnt_q + 32'(cyc);
		halt_s3 <= halt;
		aerr_s3 <= aerr;
		wb_i_q  <= idx_s3;
		wb_d_q  <= s3_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			rva_s2   <= 1'b0;
			rvb_s2   <= 1'b0;
			rvc_s2   <= 1'b0;
			wb_w_q   <= 1'b0;
			seen_q   <= 1'b0;
			cnt_q    <= '0;
			rf_vld_q <= '0;
		end else begin
			vld_s2 <= take;
			vld_s3 <= vld_s2;
			rva_s2 <= rf_vld_q[head.d.item.field_a];
			rvb_s2 <= rf_vld_q[head.d.item.field_b];
			rvc_s2 <= rf_vld_q[head.d.item.field_c];
			wb_w_q <= rf_wr;
			if (rf_wr) begin
				rf_vld_q[idx_s3] <= 1'b1;
			end
			if (vld_s2) begin
				cnt_q <= cnt_q + 32'(cyc);
				if (dec_s2.is_mem) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

	// Result of the writeback stage.
	assign res_push = vld_s3;
	always_comb begin
		res_item.next_index     = next_s3;
		res_item.reg_we         = we_s3;
		res_item.reg_index      = we_s3 ? idx_s3 : 5'd0;
		res_item.reg_value      = we_s3 ? s3_val : 32'd0;
		res_item.cycles_charged = cyc_s3;
		res_item.cycle_total    = tot_s3;
		res_item.halted         = halt_s3;
		res_item.addr_error     = aerr_s3;
	end

	a_no_issue_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !take) else $error("instruction issued during memory clear");
	a_no_write_r0: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wr |-> idx_s3 != 5'd0) else $error("write to register zero");
	a_stage_follow: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> vld_s2 ##1 vld_s3) else $error("instruction lost in pipeline");

endmodule
`default_nettype wire

// ===== hdl/mseu_outq.sv =====
// Result queue between the execute pipeline and the consumer.
`default_nettype none
module mseu_outq import mseu_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    res_push,
	input  wire result_t res_item,
	output logic [OCW-1:0] count,
	output logic         empty,
	input  wire logic    pop,
	output result_t      result
);

	localparam int unsigned PW = $clog2(OUT_DEPTH);

	result_t        q_mem [OUT_DEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [OCW-1:0] cnt_q;
	logic           rd;

	assign count  = cnt_q;
	assign empty  = cnt_q == '0;
	assign rd     = pop && !empty;
	assign result = q_mem[rp_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			q_mem[wp_q] <= res_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (res_push) begin
				wp_q <= (wp_q == PW'(OUT_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= (rp_q == PW'(OUT_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + OCW'(res_push) - OCW'(rd);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (cnt_q < OCW'(OUT_DEPTH)) || rd) else $error("result queue overflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OCW'(OUT_DEPTH)) else $error("result count out of range");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && !rd |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count not advanced");

endmodule
`default_nettype wire

// ===== hdl/mips_subset_execute_unit_top.sv =====
// Top level of the MIPS subset execute unit.
//
// This unit executes one pre-decoded instruction (add, sub, mul, slt, addi, beq, bne,
// j, lw, sw) per transfer on the instruction queue and returns one result per
// instruction on the result queue, in order. After reset the data memory is filled
// with all ones by a clearing pass over all DATA_WORDS words; instructions may be pushed
// during that pass but start to execute only when it ends. Configuration writes
// (timing enable, row and column delay) take effect at once and must only be made
// while no instruction is in flight. The front queue holds two instructions; the
// execute pipeline has three stages (register read, execute with data memory access,
// writeback). On its way to the result side an instruction passes through the front
// queue, the register read registers, the writeback registers and the result queue, and
// a new instruction can be taken every cycle while the result queue has room. Register
// values are forwarded from the writeback stage and from the register behind it, and
// loaded data is forwarded from the memory read register, so dependent instructions
// never wait. The pipeline itself never stalls: an instruction is issued only when the
// four-entry result queue has room for it and for everything already in flight, so one
// result per cycle is sustained as long as the consumer pops every cycle.
`default_nettype none
module mips_subset_execute_unit_top import mseu_pkg::*; #(
	parameter int unsigned DATA_WORDS = DATA_WORDS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire instr_t     instr,
	output logic            empty,
	input  wire logic       pop,
	output result_t         result,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [9:0] cfg_data
);

	head_t          head;
	logic           take;
	logic           res_push;
	result_t        res_item;
	logic [OCW-1:0] out_count;

	// Front end: instruction queue and classification.
	mseu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.instr  (instr),
		.take   (take),
		.head   (head)
	);

	// Back end: execution pipeline with register file and data memory.
	mseu_back #(
		.DATA_WORDS (DATA_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.take      (take),
		.out_count (out_count),
		.res_push  (res_push),
		.res_item  (res_item)
	);

	// Result queue toward the consumer.
	mseu_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_item (res_item),
		.count    (out_count),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule
`default_nettype wire
